[design/recq_pkg.sv]
package recq_pkg;

	// Width of the internal time arithmetic; differences wrap modulo 2^TIME_BITS.
	localparam int TIME_BITS = 32;

	// Fixed widths of the ports.
	localparam int NOW_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int LOCKOUT_W = 8;
	localparam int HOLD_W    = 16;

	typedef logic [TIME_BITS-1:0] time_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TURN_LOCKOUT = 2'd0,
		REG_LONG_PRESS   = 2'd1,
		REG_DOUBLE_CLICK = 2'd2
	} cfg_reg_t;

	localparam logic [LOCKOUT_W-1:0] TURN_LOCKOUT_RST = 8'd5;
	localparam logic [HOLD_W-1:0]    LONG_PRESS_RST   = 16'd1200;
	localparam logic [HOLD_W-1:0]    DOUBLE_CLICK_RST = 16'd400;

	// Switch classification codes.
	typedef enum logic [1:0] {
		CLICK_IDLE   = 2'd0,
		CLICK_SINGLE = 2'd1,
		CLICK_DOUBLE = 2'd2,
		CLICK_HOLD   = 2'd3
	} click_t;

	// Rotation step codes.
	localparam logic signed [1:0] STEP_NONE = 2'sd0;
	localparam logic signed [1:0] STEP_CW   = 2'sd1;
	localparam logic signed [1:0] STEP_CCW  = -2'sd1;

	// Two presses within the window make a double click.
	localparam logic [1:0] DOUBLE_TALLY = 2'd2;
	localparam logic [1:0] TALLY_MAX    = 2'd3;

	// One registered poll as seen by the qualifier units.
	typedef struct packed {
		time_t now;
		logic  clk_level;
		logic  dt_level;
		logic  pressed;
	} poll_t;

	function automatic time_t elapsed(input time_t now, input time_t then);
		return now - then;
	endfunction

endpackage

[design/rotary_encoder_click_qualifier_top.sv]
// Rotary encoder and push-switch qualifier. Each input request is one poll of
// the pins with a millisecond timestamp, and each poll produces exactly one
// result request carrying a rotation step (+1, -1 or 0, on a falling edge of
// the encoder clock pin, direction from the data pin) and a click code (none,
// single, double or long press). Polls enter a one-deep input register; the
// classification is computed combinationally from that register and the
// qualifier state and lands in an output register, so the block accepts one
// poll per clock cycle while the output is not stalled. The result is presented
// on the output from that output register, which is loaded when the poll
// leaves the input register. The output register decouples the two sides: a
// new poll is taken while a finished result still waits, and a stall on the
// result side backs up into in_ready only once both registers are full.
// Configuration registers (rotation lockout, long press hold time, double
// click window) are written through cfg_we, cfg_index and cfg_data and should
// only change while no poll is in flight. Timestamps wrap, and all time
// differences are taken modulo 2^32.
module rotary_encoder_click_qualifier_top (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_we,
	input  logic [recq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [recq_pkg::CFG_W-1:0]      cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [recq_pkg::NOW_W-1:0]      now_ms,
	input  logic                            clk_level,
	input  logic                            dt_level,
	input  logic                            switch_level,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [1:0]               turn_step,
	output logic [1:0]                      click_kind
);
	import recq_pkg::*;

	// Configuration registers.
	logic [LOCKOUT_W-1:0] turn_lockout_ms_q;
	logic [HOLD_W-1:0]    long_press_ms_q;
	logic [HOLD_W-1:0]    double_click_ms_q;

	// Input register stage.
	logic  valid_s1;
	poll_t poll_s1;

	// Output register stage.
	logic              out_valid_q;
	logic signed [1:0] turn_step_q;
	click_t            click_kind_q;

	logic              advance;
	logic signed [1:0] step_d;
	click_t            kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_lockout_ms_q <= TURN_LOCKOUT_RST;
			long_press_ms_q   <= LONG_PRESS_RST;
			double_click_ms_q <= DOUBLE_CLICK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TURN_LOCKOUT: turn_lockout_ms_q <= cfg_data[LOCKOUT_W-1:0];
				REG_LONG_PRESS:   long_press_ms_q   <= cfg_data[HOLD_W-1:0];
				REG_DOUBLE_CLICK: double_click_ms_q <= cfg_data[HOLD_W-1:0];
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	// The poll in the input register is consumed when the output register is
	// empty or its result is being taken in this same cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			poll_s1.now       <= time_t'(now_ms);
			poll_s1.clk_level <= clk_level;
			poll_s1.dt_level  <= dt_level;
			poll_s1.pressed   <= !switch_level;
		end
	end

	// The switch and the rotation are independent within one poll.
	recq_click u_click (
		.clk             (clk),
		.arst_n          (arst_n),
		.poll            (poll_s1),
		.advance         (advance),
		.long_press_ms   (long_press_ms_q),
		.double_click_ms (double_click_ms_q),
		.kind            (kind_d)
	);

	recq_turn u_turn (
		.clk             (clk),
		.arst_n          (arst_n),
		.poll            (poll_s1),
		.advance         (advance),
		.turn_lockout_ms (turn_lockout_ms_q),
		.step            (step_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			turn_step_q  <= step_d;
			click_kind_q <= kind_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign turn_step  = turn_step_q;
	assign click_kind = click_kind_q;

	a_empty_out_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while the output register was empty");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_valid_q && turn_step_q == $past(step_d)
			&& click_kind_q == $past(kind_d)))
		else $error("processed poll did not reach the output register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> (valid_s1 && $stable(poll_s1)))
		else $error("pending poll lost during an output stall");

endmodule

[design/recq_click.sv]
module recq_click (
	input  logic                          clk,
	input  logic                          arst_n,
	input  recq_pkg::poll_t               poll,
	input  logic                          advance,
	input  logic [recq_pkg::HOLD_W-1:0]   long_press_ms,
	input  logic [recq_pkg::HOLD_W-1:0]   double_click_ms,
	output recq_pkg::click_t              kind
);
	import recq_pkg::*;

	logic       button_was_down_q;
	logic       long_reported_q;
	logic [1:0] click_tally_q;
	time_t      press_start_time_q;
	time_t      last_click_time_q;

	logic       button_was_down_d;
	logic       long_reported_d;
	logic [1:0] click_tally_d;
	logic [1:0] tally_inc;
	time_t      press_start_time_d;
	time_t      last_click_time_d;
	logic       held_long;
	logic       in_window;

	assign held_long = elapsed(poll.now, press_start_time_q) >= time_t'(long_press_ms);
	assign in_window = elapsed(poll.now, last_click_time_q) < time_t'(double_click_ms);
	assign tally_inc = (click_tally_q < TALLY_MAX) ? click_tally_q + 2'd1 : click_tally_q;

	always_comb begin
		button_was_down_d  = button_was_down_q;
		long_reported_d    = long_reported_q;
		click_tally_d      = click_tally_q;
		press_start_time_d = press_start_time_q;
		last_click_time_d  = last_click_time_q;
		kind               = CLICK_IDLE;
		if (poll.pressed && !button_was_down_q) begin
			press_start_time_d = poll.now;
			button_was_down_d  = 1'b1;
			long_reported_d    = 1'b0;
		end else if (poll.pressed && !long_reported_q && held_long) begin
			long_reported_d = 1'b1;
			kind            = CLICK_HOLD;
		end else if (!poll.pressed && button_was_down_q) begin
			button_was_down_d = 1'b0;
			if (long_reported_q) begin
				// The release that ends a long press is swallowed.
				long_reported_d = 1'b0;
			end else if (in_window) begin
				click_tally_d = tally_inc;
				if (tally_inc >= DOUBLE_TALLY) begin
					click_tally_d     = 2'd0;
					last_click_time_d = '0;
					kind              = CLICK_DOUBLE;
				end
			end else begin
				click_tally_d     = 2'd1;
				last_click_time_d = poll.now;
				kind              = CLICK_SINGLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_was_down_q  <= 1'b0;
			long_reported_q    <= 1'b0;
			click_tally_q      <= 2'd0;
			press_start_time_q <= '0;
			last_click_time_q  <= '0;
		end else if (advance) begin
			button_was_down_q  <= button_was_down_d;
			long_reported_q    <= long_reported_d;
			click_tally_q      <= click_tally_d;
			press_start_time_q <= press_start_time_d;
			last_click_time_q  <= last_click_time_d;
		end
	end

	a_long_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind == CLICK_HOLD) |=> (long_reported_q && button_was_down_q))
		else $error("long press reported without marking the press");

	a_double_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind == CLICK_DOUBLE) |=> (click_tally_q == 2'd0 && last_click_time_q == '0))
		else $error("double click did not clear the tally");

	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		click_tally_q != DOUBLE_TALLY && click_tally_q != TALLY_MAX)
		else $error("click tally held a value of two or more");

endmodule

[design/recq_turn.sv]
module recq_turn (
	input  logic                             clk,
	input  logic                             arst_n,
	input  recq_pkg::poll_t                  poll,
	input  logic                             advance,
	input  logic [recq_pkg::LOCKOUT_W-1:0]   turn_lockout_ms,
	output logic signed [1:0]                step
);
	import recq_pkg::*;

	logic  prev_clk_q;
	time_t last_turn_time_q;
	logic  locked;
	logic  fall;

	assign locked = elapsed(poll.now, last_turn_time_q) < time_t'(turn_lockout_ms);
	assign fall   = !locked && prev_clk_q && !poll.clk_level;

	always_comb begin
		step = STEP_NONE;
		if (fall) begin
			step = poll.dt_level ? STEP_CW : STEP_CCW;
		end
	end

	// During the lockout neither the edge detector nor the stored level moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clk_q       <= 1'b1;
			last_turn_time_q <= '0;
		end else if (advance && !locked) begin
			prev_clk_q <= poll.clk_level;
			if (fall) begin
				last_turn_time_q <= poll.now;
			end
		end
	end

	a_step_clears_level: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step != STEP_NONE) |=> (!prev_clk_q && last_turn_time_q == $past(poll.now)))
		else $error("turn detected without recording the edge");

	a_locked_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && locked) |=> ($stable(prev_clk_q) && $stable(last_turn_time_q)))
		else $error("turn state moved during the lockout");

	a_locked_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && locked) |-> step == STEP_NONE)
		else $error("turn step reported during the lockout");

endmodule
